// ----- src/rotary_encoder_button_qualifier_macros.svh -----
// ----------------------------------------------------------------------------
// rotary encoder button qualifier assertion macros
// concurrent checks clocked on clk and held off while arst_n is low
// ----------------------------------------------------------------------------
`ifndef ROTARY_ENCODER_BUTTON_QUALIFIER_MACROS_SVH
`define ROTARY_ENCODER_BUTTON_QUALIFIER_MACROS_SVH

`ifndef ASSERT_OFF

// consequent must hold in the same cycle as the antecedent
`define REBQ_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rebq check failed");

// consequent must hold in the cycle after the antecedent
`define REBQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rebq check failed");

`else

`define REBQ_ASSERT_SAME(label, ante, cons)
`define REBQ_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- src/rebq_pkg.sv -----
// ----------------------------------------------------------------------------
// rebq_pkg
// shared request and result types, register indexes and reset values
// ----------------------------------------------------------------------------
`default_nettype none

package rebq_pkg;

	// configuration port
	localparam int CFG_INDEX_BITS = 1;
	localparam int CFG_DATA_BITS  = 20;
	localparam int DEBOUNCE_BITS  = 16;
	localparam int LONG_BITS      = 20;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_DEBOUNCE   = 1'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_LONG_PRESS = 1'd1;

	localparam logic [DEBOUNCE_BITS-1:0] DEBOUNCE_RESET = 16'd40;
	localparam logic [LONG_BITS-1:0]     LONG_RESET     = 20'd5000;

	// field widths
	localparam int NOW_BITS     = 32;
	localparam int POS_OUT_BITS = 16;
	// common width for timestamp and threshold compares
	localparam int CMP_BITS     = 32;

	typedef struct packed {
		logic                clk_level;
		logic                dt_level;
		logic                switch_level;
		logic [NOW_BITS-1:0] now_ms;
	} sample_t;

	typedef struct packed {
		logic signed [POS_OUT_BITS-1:0] position;
		logic                           pressed;
		logic                           clicked;
		logic                           long_pressed;
	} result_t;

	typedef struct packed {
		logic [DEBOUNCE_BITS-1:0] debounce_ms;
		logic [LONG_BITS-1:0]     long_press_ms;
	} cfg_t;

	typedef struct packed {
		logic pressed;
		logic clicked;
		logic long_pressed;
	} sw_status_t;

endpackage

`default_nettype wire

// ----- src/rotary_encoder_button_qualifier.sv -----
// ----------------------------------------------------------------------------
// rotary_encoder_button_qualifier: encoder position and qualified switch
// an accepted request passes the input register, then the result register, to result valid
// throughput one request per cycle while result_stall does not hold the result register
// reset: position 0, channel a high, switch released, debounce 40 ms, long press 5000 ms
// ----------------------------------------------------------------------------
`default_nettype none
`include "rotary_encoder_button_qualifier_macros.svh"

module rotary_encoder_button_qualifier #(
	parameter int POSITION_BITS = 16,
	parameter int TIME_BITS     = 32
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_we,
	input  wire logic [rebq_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  wire logic [rebq_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	input  wire logic                                  sample_valid,
	output      logic                                  sample_stall,
	input  wire rebq_pkg::sample_t                     sample,
	output      logic                                  result_valid,
	input  wire logic                                  result_stall,
	output      rebq_pkg::result_t                     result
);

	localparam int OW = rebq_pkg::POS_OUT_BITS;
	localparam int DW = rebq_pkg::DEBOUNCE_BITS;
	localparam int LW = rebq_pkg::LONG_BITS;

	rebq_pkg::cfg_t       cfg_q;
	logic                 valid_s1;
	rebq_pkg::sample_t    sample_s1;
	rebq_pkg::result_t    result_s2;
	logic                 advance;
	logic                 take;
	logic signed [POSITION_BITS-1:0] pos_next;
	rebq_pkg::sw_status_t sw_status;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms   <= rebq_pkg::DEBOUNCE_RESET;
			cfg_q.long_press_ms <= rebq_pkg::LONG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				rebq_pkg::CFG_DEBOUNCE:   cfg_q.debounce_ms   <= cfg_data[DW-1:0];
				rebq_pkg::CFG_LONG_PRESS: cfg_q.long_press_ms <= cfg_data[LW-1:0];
				default: ;
			endcase
		end
	end

	// handshake: stage 1 moves on whenever the result register can take it
	assign advance      = valid_s1 && (!result_valid || !result_stall);
	assign sample_stall = valid_s1 && !advance;
	assign take         = sample_valid && !sample_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			sample_s1 <= sample;
		end
	end

	rebq_quad #(
		.POSITION_BITS(POSITION_BITS)
	) u_quad (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.a       (sample_s1.clk_level),
		.b       (sample_s1.dt_level),
		.count   (pos_next)
	);

	rebq_switch #(
		.TIME_BITS(TIME_BITS)
	) u_switch (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.raw_pressed (~sample_s1.switch_level),
		.now         (sample_s1.now_ms[TIME_BITS-1:0]),
		.cfg         (cfg_q),
		.status      (sw_status)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2.position     <= OW'(pos_next);
			result_s2.pressed      <= sw_status.pressed;
			result_s2.clicked      <= sw_status.clicked;
			result_s2.long_pressed <= sw_status.long_pressed;
		end
	end

	assign result = result_s2;

	// checks
	`REBQ_ASSERT_SAME(a_pulse_excl, result_valid, !(result.clicked && result.long_pressed))
	`REBQ_ASSERT_SAME(a_click_released, result_valid && result.clicked, !result.pressed)
	`REBQ_ASSERT_SAME(a_long_held, result_valid && result.long_pressed, result.pressed)
	`REBQ_ASSERT_NEXT(a_s1_hold, valid_s1 && !advance, valid_s1)

endmodule

`default_nettype wire

// ----- src/rebq_quad.sv -----
// ----------------------------------------------------------------------------
// rebq_quad
// quadrature step counter: every change of channel a steps the position
// ----------------------------------------------------------------------------
`default_nettype none

module rebq_quad #(
	parameter int POSITION_BITS = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            advance,
	input  wire logic                            a,
	input  wire logic                            b,
	output      logic signed [POSITION_BITS-1:0] count
);

	logic                     prev_a_q;
	logic [POSITION_BITS-1:0] count_q;
	logic [POSITION_BITS-1:0] count_next;

	// step up when a equals b, down otherwise, wrapping
	always_comb begin
		count_next = count_q;
		if (a != prev_a_q) begin
			if (a == b) begin
				count_next = count_q + POSITION_BITS'(1);
			end else begin
				count_next = count_q - POSITION_BITS'(1);
			end
		end
	end

	assign count = $signed(count_next);

	// encoder state, updated once per request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_a_q <= 1'b1;
			count_q  <= '0;
		end else if (advance) begin
			prev_a_q <= a;
			count_q  <= count_next;
		end
	end

endmodule

`default_nettype wire

// ----- src/rebq_switch.sv -----
// ----------------------------------------------------------------------------
// rebq_switch
// switch debounce with click and long-press qualification
// ----------------------------------------------------------------------------
`default_nettype none

module rebq_switch #(
	parameter int TIME_BITS = 32
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       advance,
	input  wire logic                       raw_pressed,
	input  wire logic [TIME_BITS-1:0]       now,
	input  wire rebq_pkg::cfg_t             cfg,
	output      rebq_pkg::sw_status_t       status
);

	localparam int CW = rebq_pkg::CMP_BITS;

	logic                 prev_raw_q;
	logic                 stable_q;
	logic [TIME_BITS-1:0] change_time_q;
	logic [TIME_BITS-1:0] press_start_q;
	logic                 latched_q;

	logic                 stable_n;
	logic [TIME_BITS-1:0] change_time_n;
	logic [TIME_BITS-1:0] press_start_n;
	logic                 latched_n;
	logic [TIME_BITS-1:0] since_change;
	logic [TIME_BITS-1:0] since_press;
	logic                 accept;
	logic                 press_begins;
	logic                 click;
	logic                 long_hit;

	// raw change restarts the debounce window
	assign change_time_n = (raw_pressed != prev_raw_q) ? now : change_time_q;
	assign since_change  = now - change_time_n;
	assign since_press   = now - press_start_q;

	assign accept = (CW'(since_change) > CW'(cfg.debounce_ms)) && (raw_pressed != stable_q);
	assign press_begins = accept && raw_pressed;

	// accepted edge: a press restarts the hold time, a release may click
	always_comb begin
		stable_n      = stable_q;
		press_start_n = press_start_q;
		latched_n     = latched_q;
		click         = 1'b0;
		if (accept) begin
			stable_n = raw_pressed;
			if (raw_pressed) begin
				press_start_n = now;
				latched_n     = 1'b0;
			end else begin
				click = (CW'(since_press) < CW'(cfg.long_press_ms)) && !latched_q;
			end
		end
		// hold time is zero on the request that starts the press
		long_hit = stable_n && !latched_n &&
			((press_begins ? CW'(0) : CW'(since_press)) >= CW'(cfg.long_press_ms));
		if (long_hit) begin
			latched_n = 1'b1;
		end
	end

	assign status.pressed      = stable_n;
	assign status.clicked      = click;
	assign status.long_pressed = long_hit;

	// switch state, updated once per request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_raw_q    <= 1'b0;
			stable_q      <= 1'b0;
			change_time_q <= '0;
			press_start_q <= '0;
			latched_q     <= 1'b0;
		end else if (advance) begin
			prev_raw_q    <= raw_pressed;
			stable_q      <= stable_n;
			change_time_q <= change_time_n;
			press_start_q <= press_start_n;
			latched_q     <= latched_n;
		end
	end

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb: rotary encoder button qualifier testbench
// a directed plan covers the encoder edges, the debounce boundary, the
// timestamp wrap, long press, click and the extreme register settings. random
// phases then drive pin traces with bouncing presses under several settings,
// plus a short steady encoder spin. every result is checked in order against
// a local model of the qualifier or against the expected values of the plan.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

	localparam int CIW = rebq_pkg::CFG_INDEX_BITS;
	localparam int CDW = rebq_pkg::CFG_DATA_BITS;
	localparam int DBW = rebq_pkg::DEBOUNCE_BITS;
	localparam int LPW = rebq_pkg::LONG_BITS;
	localparam int PW  = rebq_pkg::POS_OUT_BITS;
	localparam int NW  = rebq_pkg::NOW_BITS;

	typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

	typedef struct {
		row_kind_t          kind;
		rebq_pkg::sample_t  smp;
		logic [CIW-1:0]     reg_idx;
		logic [CDW-1:0]     reg_val;
		bit                 known;
		rebq_pkg::result_t  want;
	} plan_row_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [CIW-1:0]     cfg_index;
	logic [CDW-1:0]     cfg_data;
	logic               sample_valid;
	logic               sample_stall;
	rebq_pkg::sample_t  sample;
	logic               result_valid;
	logic               result_stall;
	rebq_pkg::result_t  result;

	// model copy of registers and qualifier state
	logic [DBW-1:0] deb_ms;
	logic [LPW-1:0] long_ms;
	logic           enc_prev_a;
	logic [PW-1:0]  step_pos;
	logic           raw_prev;
	logic           deb_pressed;
	logic           long_done;
	logic [NW-1:0]  change_ts;
	logic [NW-1:0]  press_ts;

	rebq_pkg::result_t pending_results[$];
	plan_row_t         plan_q[$];
	int                mismatch_count;
	bit                idle_on;
	bit                hold_req;

	rotary_encoder_button_qualifier uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// run limit
	initial begin
		#12_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// step the local qualifier by one sample and return its result
	function automatic rebq_pkg::result_t qualify_sample(input rebq_pkg::sample_t s);
		rebq_pkg::result_t r;
		logic              raw;
		logic [NW-1:0]     since_change;
		logic [NW-1:0]     since_press;
		raw = ~s.switch_level;
		r = '0;
		if (s.clk_level != enc_prev_a) begin
			if (s.clk_level == s.dt_level)
				step_pos = step_pos + PW'(1);
			else
				step_pos = step_pos - PW'(1);
			enc_prev_a = s.clk_level;
		end
		if (raw != raw_prev) begin
			raw_prev = raw;
			change_ts = s.now_ms;
		end
		since_change = s.now_ms - change_ts;
		if (since_change > {16'd0, deb_ms} && raw != deb_pressed) begin
			deb_pressed = raw;
			since_press = s.now_ms - press_ts;
			if (deb_pressed) begin
				press_ts = s.now_ms;
				long_done = 1'b0;
			end else if (since_press < {12'd0, long_ms} && !long_done) begin
				r.clicked = 1'b1;
			end
		end
		since_press = s.now_ms - press_ts;
		if (deb_pressed && !long_done && since_press >= {12'd0, long_ms}) begin
			long_done = 1'b1;
			r.long_pressed = 1'b1;
		end
		r.position = step_pos;
		r.pressed = deb_pressed;
		return r;
	endfunction

	// idle cycles before a request or between accepted results
	function automatic int draw_gap();
		if (!idle_on || $urandom_range(0, 2) == 0)
			return 0;
		return $urandom_range(0, 16);
	endfunction

	// timestamp advance, mostly short, sometimes near the thresholds
	function automatic logic [NW-1:0] draw_step();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 5)
			return $urandom_range(0, 3);
		if (sel < 8)
			return $urandom_range(0, int'(deb_ms) + 8);
		if (sel == 8)
			return $urandom_range(0, int'(long_ms) / 4 + 8);
		return $urandom_range(0, int'(long_ms) + int'(long_ms) / 2 + 8);
	endfunction

	// offer one request, hold it until taken, then queue its result
	task automatic offer(input rebq_pkg::sample_t s, input bit known,
			input rebq_pkg::result_t want);
		int                gap;
		rebq_pkg::result_t guess;
		gap = draw_gap();
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= s;
		@(posedge clk);
		while (sample_stall) @(posedge clk);
		guess = qualify_sample(s);
		pending_results.push_back(known ? want : guess);
	endtask

	// register write once the block has drained
	task automatic write_reg(input logic [CIW-1:0] idx, input int val);
		sample_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CDW'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == rebq_pkg::CFG_DEBOUNCE)
			deb_ms = DBW'(val);
		else
			long_ms = LPW'(val);
	endtask

	task automatic add_sample(input logic a, input logic b, input logic sw,
			input logic [NW-1:0] now);
		plan_row_t row;
		row = '{ROW_SAMPLE, '0, '0, '0, 1'b0, '0};
		row.smp = '{a, b, sw, now};
		plan_q.push_back(row);
	endtask

	task automatic add_known(input logic a, input logic b, input logic sw,
			input logic [NW-1:0] now, input int pos, input logic p,
			input logic c, input logic l);
		plan_row_t row;
		row = '{ROW_SAMPLE, '0, '0, '0, 1'b1, '0};
		row.smp = '{a, b, sw, now};
		row.want.position = PW'(pos);
		row.want.pressed = p;
		row.want.clicked = c;
		row.want.long_pressed = l;
		plan_q.push_back(row);
	endtask

	task automatic add_write(input logic [CIW-1:0] idx, input int val);
		plan_row_t row;
		row = '{ROW_WRITE, '0, idx, CDW'(val), 1'b0, '0};
		plan_q.push_back(row);
	endtask

	// random pin trace: well-formed encoder and switch activity with noise
	task automatic run_phase(input int n_items, input logic [NW-1:0] start_ms);
		rebq_pkg::sample_t s;
		logic [NW-1:0]     cursor;
		logic [1:0]        gray;
		logic              dir_down;
		logic              sw_level;
		int                sel;
		cursor = start_ms;
		gray = 2'd2;
		dir_down = 1'($urandom_range(0, 1));
		sw_level = 1'b1;
		for (int i = 0; i < n_items; i++) begin
			if ($urandom_range(0, 99) < 10) begin
				// noise request
				s.clk_level = 1'($urandom_range(0, 1));
				s.dt_level = 1'($urandom_range(0, 1));
				s.switch_level = 1'($urandom_range(0, 1));
				s.now_ms = $urandom;
			end else begin
				cursor = cursor + draw_step();
				if ($urandom_range(0, 7) == 0)
					sw_level = ~sw_level;
				if ($urandom_range(0, 15) == 0)
					dir_down = ~dir_down;
				sel = $urandom_range(0, 9);
				if (sel < 7)
					gray = gray + (dir_down ? 2'd3 : 2'd1);
				else if (sel == 9)
					gray = 2'($urandom_range(0, 3));
				s.clk_level = gray[0] ^ gray[1];
				s.dt_level = gray[1];
				// occasional contact bounce against the held level
				s.switch_level = ($urandom_range(0, 6) == 0) ? ~sw_level : sw_level;
				s.now_ms = cursor;
			end
			offer(s, 1'b0, '0);
		end
	endtask

	// result checker
	always @(posedge clk) begin
		rebq_pkg::result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				$error("result with no request waiting");
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (result.position !== want.position) begin
					$error("position: expected %0d, got %0d", want.position, result.position);
					mismatch_count++;
				end
				if (result.pressed !== want.pressed) begin
					$error("pressed: expected %0b, got %0b", want.pressed, result.pressed);
					mismatch_count++;
				end
				if (result.clicked !== want.clicked) begin
					$error("clicked: expected %0b, got %0b", want.clicked, result.clicked);
					mismatch_count++;
				end
				if (result.long_pressed !== want.long_pressed) begin
					$error("long_pressed: expected %0b, got %0b", want.long_pressed,
						result.long_pressed);
					mismatch_count++;
				end
			end
		end
	end

	// result side back-pressure, with one long hold-off on request
	initial begin
		int n;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_req) begin
				n = 200;
				hold_req = 1'b0;
			end else begin
				n = draw_gap();
			end
			if (n > 0) begin
				result_stall <= 1'b1;
				repeat (n) @(posedge clk);
				result_stall <= 1'b0;
			end
			@(posedge clk);
			while (!result_valid) @(posedge clk);
		end
	end

	// stimulus
	initial begin
		rebq_pkg::sample_t s;
		logic [NW-1:0]     cursor;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		sample_valid = 1'b0;
		sample = '0;
		result_stall = 1'b0;
		mismatch_count = 0;
		idle_on = 1'b1;
		hold_req = 1'b0;
		deb_ms = rebq_pkg::DEBOUNCE_RESET;
		long_ms = rebq_pkg::LONG_RESET;
		enc_prev_a = 1'b1;
		step_pos = '0;
		raw_prev = 1'b0;
		deb_pressed = 1'b0;
		long_done = 1'b0;
		change_ts = '0;
		press_ts = '0;

		// encoder steps in both directions from reset
		add_known(1, 1, 1, 0, 0, 0, 0, 0);
		add_known(0, 1, 1, 1, -1, 0, 0, 0);
		add_known(1, 1, 1, 2, 0, 0, 0, 0);
		add_known(0, 0, 1, 3, 1, 0, 0, 0);
		add_known(1, 0, 1, 4, 0, 0, 0, 0);
		// press across the timestamp wrap, debounce edge, then long press
		add_known(1, 1, 0, 32'hFFFF_FFFF, 0, 0, 0, 0);
		add_known(1, 1, 0, 39, 0, 0, 0, 0);
		add_known(1, 1, 0, 40, 0, 1, 0, 0);
		add_known(1, 1, 0, 5040, 0, 1, 0, 1);
		add_known(1, 1, 0, 5041, 0, 1, 0, 0);
		add_known(1, 1, 1, 5042, 0, 1, 0, 0);
		add_known(1, 1, 1, 5083, 0, 0, 0, 0);
		// short press with bounce on release gives a click
		add_known(1, 1, 0, 6000, 0, 0, 0, 0);
		add_known(1, 1, 0, 6041, 0, 1, 0, 0);
		add_sample(1, 1, 1, 6050);
		add_sample(1, 1, 0, 6060);
		add_sample(1, 1, 1, 6100);
		add_known(1, 1, 1, 6141, 0, 0, 1, 0);
		// zero debounce and zero long press time
		add_write(rebq_pkg::CFG_DEBOUNCE, 0);
		add_write(rebq_pkg::CFG_LONG_PRESS, 0);
		add_known(1, 1, 0, 7000, 0, 0, 0, 0);
		add_known(1, 1, 0, 7001, 0, 1, 0, 1);
		add_known(1, 1, 1, 7002, 0, 1, 0, 0);
		add_known(1, 1, 1, 7003, 0, 0, 0, 0);
		// largest debounce setting and a large long press time
		add_write(rebq_pkg::CFG_DEBOUNCE, 65535);
		add_write(rebq_pkg::CFG_LONG_PRESS, 1000000);
		add_known(1, 1, 0, 10000, 0, 0, 0, 0);
		add_known(1, 1, 0, 75536, 0, 1, 0, 0);
		add_known(1, 1, 0, 1075536, 0, 1, 0, 1);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan_q[i]) begin
			if (plan_q[i].kind == ROW_WRITE)
				write_reg(plan_q[i].reg_idx, int'(plan_q[i].reg_val));
			else
				offer(plan_q[i].smp, plan_q[i].known, plan_q[i].want);
		end

		// random phases over a spread of settings
		write_reg(rebq_pkg::CFG_DEBOUNCE, int'(rebq_pkg::DEBOUNCE_RESET));
		write_reg(rebq_pkg::CFG_LONG_PRESS, int'(rebq_pkg::LONG_RESET));
		run_phase(150, 32'd2_000_000);

		write_reg(rebq_pkg::CFG_DEBOUNCE, 5);
		write_reg(rebq_pkg::CFG_LONG_PRESS, 300);
		run_phase(150, 32'hFFFF_F000);

		// receiver holds off while requests keep coming
		write_reg(rebq_pkg::CFG_DEBOUNCE, 10);
		write_reg(rebq_pkg::CFG_LONG_PRESS, 800);
		hold_req = 1'b1;
		run_phase(150, $urandom);

		// back to back, no idling on either side
		idle_on = 1'b0;
		write_reg(rebq_pkg::CFG_DEBOUNCE, 0);
		write_reg(rebq_pkg::CFG_LONG_PRESS, 0);
		run_phase(120, $urandom);
		idle_on = 1'b1;

		write_reg(rebq_pkg::CFG_DEBOUNCE, 65535);
		write_reg(rebq_pkg::CFG_LONG_PRESS, 1000000);
		run_phase(80, 32'hFFF0_0000);

		write_reg(rebq_pkg::CFG_DEBOUNCE, $urandom_range(0, 300));
		write_reg(rebq_pkg::CFG_LONG_PRESS, $urandom_range(0, 20000));
		run_phase(150, $urandom);

		write_reg(rebq_pkg::CFG_DEBOUNCE, 1);
		write_reg(rebq_pkg::CFG_LONG_PRESS, 1);
		run_phase(100, $urandom);

		write_reg(rebq_pkg::CFG_DEBOUNCE, $urandom_range(0, 65535));
		write_reg(rebq_pkg::CFG_LONG_PRESS, $urandom_range(0, 1000000));
		run_phase(100, $urandom);

		// steady spin downwards with no idling
		idle_on = 1'b0;
		cursor = $urandom;
		for (int i = 0; i < 25; i++) begin
			cursor = cursor + 1;
			s.clk_level = i[0];
			s.dt_level = ~i[0];
			s.switch_level = 1'b1;
			s.now_ms = cursor;
			offer(s, 1'b0, '0);
		end
		idle_on = 1'b1;

		// drain and finish
		sample_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

`default_nettype wire
